/* src/sfd_pkg.sv */
package sfd_pkg;

  // width of the frame byte counter
  localparam int LENGTH_BITS = 16;
  // width of the frame_length result field
  localparam int FRAME_LEN_BITS = 16;
  // common width for the limit compare
  localparam int CMP_BITS = (LENGTH_BITS > FRAME_LEN_BITS) ? LENGTH_BITS : FRAME_LEN_BITS;

  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  // byte classes found by the front end
  localparam logic [2:0] CLS_OTHER   = 3'd0;
  localparam logic [2:0] CLS_END     = 3'd1;
  localparam logic [2:0] CLS_ESC     = 3'd2;
  localparam logic [2:0] CLS_ESC_END = 3'd3;
  localparam logic [2:0] CLS_ESC_ESC = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_DATA       = 2'd0;
  localparam logic [1:0] KIND_OK         = 2'd1;
  localparam logic [1:0] KIND_BAD_ESCAPE = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW   = 2'd3;

  // decoder modes
  localparam logic [1:0] MODE_HUNT    = 2'd0;
  localparam logic [1:0] MODE_OPENED  = 2'd1;
  localparam logic [1:0] MODE_FRAME   = 2'd2;
  localparam logic [1:0] MODE_ESCAPED = 2'd3;

  typedef struct packed {
    logic [7:0] value;
    logic [2:0] cls;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } slot_t;

endpackage

/* src/sfd_front.sv */
module sfd_front
  import sfd_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       q_ready,
  output slot_t      push
);

  logic [2:0] cls;

  always_comb begin
    case (in_byte)
      CODE_END:     cls = CLS_END;
      CODE_ESC:     cls = CLS_ESC;
      CODE_ESC_END: cls = CLS_ESC_END;
      CODE_ESC_ESC: cls = CLS_ESC_ESC;
      default:      cls = CLS_OTHER;
    endcase
  end

  assign in_ready          = q_ready;
  assign push.valid        = in_valid & q_ready;
  assign push.entry.value  = in_byte;
  assign push.entry.cls    = cls;

endmodule

/* src/sfd_queue.sv */
module sfd_queue
  import sfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  slot_t push,
  output logic  ready,
  output slot_t head,
  input  logic  pop
);

  entry_t     ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       do_pop;

  assign ready      = (cnt != 2'd2);
  assign head.valid = (cnt != 2'd0);
  assign head.entry = ent[rd_ptr];
  assign do_pop     = pop & head.valid;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push.valid, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* src/sfd_back.sv */
module sfd_back
  import sfd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  slot_t                      head,
  output logic                       pop,
  input  logic                       cfg_we,
  input  logic [15:0]                cfg_wdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_kind,
  output logic [7:0]                 out_byte,
  output logic [FRAME_LEN_BITS-1:0]  out_len
);

  logic [1:0]             mode;
  logic [1:0]             mode_next;
  logic [LENGTH_BITS-1:0] count;
  logic [LENGTH_BITS-1:0] count_next;
  logic [LENGTH_BITS-1:0] count_base;
  logic [15:0]            max_len;

  logic                      res;
  logic [1:0]                kind_next;
  logic [7:0]                byte_next;
  logic [FRAME_LEN_BITS-1:0] len_next;
  logic                      pay;
  logic [7:0]                pay_byte;
  logic                      over;

  assign pop = head.valid & (~out_valid | out_ready);

  assign count_base = (mode == MODE_OPENED) ? '0 : count;
  assign over = (CMP_BITS'(count_base) >= CMP_BITS'(max_len)) || (count_base == '1);

  always_comb begin
    mode_next  = mode;
    count_next = count;
    res        = 1'b0;
    kind_next  = KIND_DATA;
    byte_next  = 8'd0;
    len_next   = '0;
    pay        = 1'b0;
    pay_byte   = head.entry.value;
    case (mode)
      MODE_HUNT: begin
        if (head.entry.cls == CLS_END) begin
          mode_next  = MODE_OPENED;
          count_next = '0;
        end
      end
      MODE_OPENED, MODE_FRAME: begin
        if (head.entry.cls == CLS_END) begin
          if (mode == MODE_FRAME) begin
            res        = 1'b1;
            kind_next  = KIND_OK;
            len_next   = FRAME_LEN_BITS'(count);
            mode_next  = MODE_HUNT;
            count_next = '0;
          end
        end else if (head.entry.cls == CLS_ESC) begin
          mode_next  = MODE_ESCAPED;
          count_next = count_base;
        end else begin
          pay = 1'b1;
        end
      end
      default: begin
        if (head.entry.cls == CLS_ESC_END) begin
          pay      = 1'b1;
          pay_byte = CODE_END;
        end else if (head.entry.cls == CLS_ESC_ESC) begin
          pay      = 1'b1;
          pay_byte = CODE_ESC;
        end else begin
          res        = 1'b1;
          kind_next  = KIND_BAD_ESCAPE;
          mode_next  = MODE_HUNT;
          count_next = '0;
        end
      end
    endcase
    if (pay) begin
      res = 1'b1;
      if (over) begin
        kind_next  = KIND_OVERFLOW;
        mode_next  = MODE_HUNT;
        count_next = '0;
      end else begin
        kind_next  = KIND_DATA;
        byte_next  = pay_byte;
        mode_next  = MODE_FRAME;
        count_next = LENGTH_BITS'(count_base + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_HUNT;
      count     <= '0;
      max_len   <= 16'hFFFF;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (pop) begin
        mode      <= mode_next;
        count     <= count_next;
        out_valid <= res;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res) begin
      out_kind <= kind_next;
      out_byte <= byte_next;
      out_len  <= len_next;
    end
  end

  // a frame end or an error always sends the decoder back to hunting
  a_end_hunts: assert property (@(posedge clk) disable iff (rst)
    (pop && res && kind_next != KIND_DATA) |=> (mode == MODE_HUNT && count == '0))
    else $error("decoder not hunting after frame end or error");

  // a pending data item means the frame is open and counted
  a_data_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_DATA) |-> (mode == MODE_FRAME && count != '0))
    else $error("data item pending without an open counted frame");

  // a good frame end never reports an empty frame
  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_kind == KIND_OK) |-> (out_len != '0 && mode == MODE_HUNT))
    else $error("ok marker with zero length");

endmodule

/* src/slip_frame_decoder.sv */
// SLIP receive decoder. Raw bytes enter on the s_ stream one item per cycle and
// leave as decoded items on the m_ stream: a data byte (kind 0), a frame end with
// its payload length (kind 1), a bad escape (kind 2) or an overflow past
// max_frame_length (kind 3). On either error the bytes of that frame already sent
// must be dropped downstream. Bytes before the first END, after a closing END and
// after an error are discarded until the next END; repeated ENDs give nothing.
// Sustained rate is one item per cycle in and out while neither stream stalls; an
// item's result is offered on m_ once its byte has passed through the two-entry
// queue and then the output register. The front end classifies bytes into the
// queue, the back end runs the mode/count update once per cycle while it can pop
// a byte and is the only serial part.
// cfg_we writes max_frame_length; write it only while the block is idle.
module slip_frame_decoder
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // raw byte stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  // decoded stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // data_byte[7:0], frame_length[23:8]
  output logic [1:0]  m_tuser,   // kind[1:0]
  // max_frame_length register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  slot_t                     push;
  slot_t                     head;
  logic                      q_ready;
  logic                      pop;
  logic [7:0]                out_byte;
  logic [FRAME_LEN_BITS-1:0] out_len;

  // front end: handshake and byte classification
  sfd_front u_front (
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .q_ready  (q_ready),
    .push     (push)
  );

  // two-entry queue lets input and output stall independently
  sfd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .ready (q_ready),
    .head  (head),
    .pop   (pop)
  );

  // back end: framing state, byte count, limit check, output register
  sfd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (m_tuser),
    .out_byte  (out_byte),
    .out_len   (out_len)
  );

  assign m_tdata = {out_len, out_byte};

endmodule
